/* hw/rtl/bdy_pkg.sv */
package bdy_pkg;

   localparam int unsigned ROW_W = 32;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_OOM      = 3'd2;
   localparam logic [2:0] ST_OOB      = 3'd3;
   localparam logic [2:0] ST_DISABLED = 3'd4;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_REGION_BASE = 1'b0;
   localparam logic CSR_ENABLED     = 1'b1;

   typedef struct packed {
      logic        func;
      logic [16:0] req_size;
      logic [31:0] req_address;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [2:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLR,
      S_SRD,
      S_SCHK,
      S_FRD,
      S_FCHK,
      S_WRD,
      S_WMOD
   } state_type;

endpackage

/* hw/rtl/bdy_map.sv */
module bdy_map #(
   parameter int ROWS = 512,
   parameter int RW   = 9
) (
   input  logic                       clock,
   input  logic [RW-1:0]              rd_addr,
   output logic [bdy_pkg::ROW_W-1:0]  rd_data,
   input  logic                       wr_en,
   input  logic [RW-1:0]              wr_addr,
   input  logic [bdy_pkg::ROW_W-1:0]  wr_data
);
   import bdy_pkg::*;

   logic [ROW_W-1:0] mem [ROWS];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/buddy_allocator.sv */
// Errors answer the cycle after start. Allocate: S_SRD, S_SCHK per free-map row
// scanned; S_WRD, S_WMOD per block written (the taken block, then one per split level).
// Free: S_FRD, S_FCHK per buddy probed; S_WRD, S_WMOD for the final write; one more
// S_FRD if it reaches the root. One request at a time; the result strobe follows the
// last step, with busy low. Reset: clears the free map one row per cycle (busy held
// high), leaving only the whole region free. Results are a one-cycle strobe.
module buddy_allocator #(
   parameter int MAX_ORDER = 16,
   parameter int MIN_ORDER = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bdy_pkg::req_type req_item,
   output logic             rsp_valid,
   output bdy_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);
   import bdy_pkg::*;

   localparam int NW    = MAX_ORDER - MIN_ORDER + 1;
   localparam int XW    = ((NW > 5) ? NW : 5) + 1;
   localparam int ROWS  = (((1 << NW) - 1) + ROW_W - 1) / ROW_W;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int KW    = $clog2(MAX_ORDER + 1);
   localparam int OW    = MAX_ORDER;
   localparam logic [KW-1:0] KMAX = KW'(MAX_ORDER);
   localparam logic [KW-1:0] KMIN = KW'(MIN_ORDER);

   state_type        state_ff, state_in;
   logic [31:0]      base_ff, base_in;
   logic             en_ff, en_in;
   logic             alloc_ff, alloc_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [KW-1:0]    lvl_ff, lvl_in;
   logic [OW-1:0]    off_ff, off_in;
   logic [XW-1:0]    cur_ff, cur_in;
   logic [XW-1:0]    end_ff, end_in;
   logic [KW-1:0]    tlvl_ff, tlvl_in;
   logic [OW-1:0]    toff_ff, toff_in;
   logic             tval_ff, tval_in;
   logic [RW-1:0]    clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [RW-1:0]    rd_addr, wr_addr;
   logic [ROW_W-1:0] rd_data, wr_data;
   logic             wr_en;

   function automatic logic [XW-1:0] lvl_base(input logic [KW-1:0] k);
      return (XW'(1) << (KMAX - k)) - XW'(1);
   endfunction

   function automatic logic [XW-1:0] node_idx(input logic [KW-1:0] k,
                                              input logic [OW-1:0] off);
      return lvl_base(k) + XW'(off >> k);
   endfunction

   function automatic logic [KW-1:0] order_of(input logic [16:0] size);
      logic [KW-1:0] k;
      k = KMIN;
      for (int i = MIN_ORDER; i < MAX_ORDER; i++) begin
         if ((34'(1) << i) < 34'(size)) begin
            k = KW'(i + 1);
         end
      end
      return k;
   endfunction

   bdy_map #(.ROWS(ROWS), .RW(RW)) u_map (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         base_ff      <= '0;
         en_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         en_ff        <= en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      alloc_ff <= alloc_in;
      k_ff     <= k_in;
      lvl_ff   <= lvl_in;
      off_ff   <= off_in;
      cur_ff   <= cur_in;
      end_ff   <= end_in;
      tlvl_ff  <= tlvl_in;
      toff_ff  <= toff_in;
      tval_ff  <= tval_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      logic [KW-1:0]  ord;
      logic           bad_size;
      logic           oob;
      logic [33:0]    addr_end;
      logic [31:0]    rel;
      logic [XW-1:0]  row_base;
      logic [XW-1:0]  idx;
      logic [XW-1:0]  hit_node;
      logic           hit;
      logic [XW-1:0]  next_row;
      logic [XW-1:0]  bn;
      logic [XW-1:0]  tn;
      logic [OW-1:0]  found_off;
      logic [ROW_W-1:0] row_mod;

      state_in     = state_ff;
      base_in      = base_ff;
      en_in        = en_ff;
      alloc_in     = alloc_ff;
      k_in         = k_ff;
      lvl_in       = lvl_ff;
      off_in       = off_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      tlvl_in      = tlvl_ff;
      toff_in      = toff_ff;
      tval_in      = tval_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;

      ord      = order_of(req_item.req_size);
      bad_size = (req_item.req_size == '0) ||
                 (34'(req_item.req_size) > (34'(1) << MAX_ORDER));
      addr_end = 34'(base_ff) + (34'(1) << MAX_ORDER);
      oob      = (req_item.req_address < base_ff) ||
                 (34'(req_item.req_address) >= addr_end);
      rel      = req_item.req_address - base_ff;

      row_base = cur_ff & ~XW'(ROW_W - 1);
      hit      = 1'b0;
      hit_node = '0;
      for (int b = ROW_W - 1; b >= 0; b--) begin
         idx = row_base + XW'(b);
         if (rd_data[b] && idx >= cur_ff && idx < end_ff) begin
            hit      = 1'b1;
            hit_node = idx;
         end
      end
      next_row  = row_base + XW'(ROW_W);
      found_off = OW'(hit_node - lvl_base(lvl_ff)) << lvl_ff;

      bn = (lvl_ff < KMAX) ? node_idx(lvl_ff, off_ff ^ (OW'(1) << lvl_ff)) : '0;
      tn = node_idx(tlvl_ff, toff_ff);
      row_mod = rd_data;
      row_mod[tn[4:0]] = tval_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_REGION_BASE: base_in = csr_data;
            CSR_ENABLED:     en_in   = csr_data[0];
            default:         ;
         endcase
      end

      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == '0) ? ROW_W'(1) : '0;
            clr_in  = clr_ff + RW'(1);
            if (clr_ff == RW'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               alloc_in     = (req_item.func == FUNC_ALLOC);
               k_in         = ord;
               lvl_in       = ord;
               rsp_in       = '0;
               if (req_item.func == FUNC_ALLOC) begin
                  if (!en_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_DISABLED;
                  end else if (bad_size) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_BAD_SIZE;
                  end else begin
                     cur_in   = lvl_base(ord);
                     end_in   = (lvl_base(ord) << 1) + XW'(1);
                     state_in = S_SRD;
                  end
               end else begin
                  if (oob) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_OOB;
                  end else if (bad_size) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_BAD_SIZE;
                  end else begin
                     off_in   = OW'(rel) & ~((OW'(1) << ord) - OW'(1));
                     state_in = S_FRD;
                  end
               end
            end
         end
         S_SRD: begin
            rd_addr  = cur_ff[5 +: RW];
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (hit) begin
               off_in   = found_off;
               tlvl_in  = lvl_ff;
               toff_in  = found_off;
               tval_in  = 1'b0;
               state_in = S_WRD;
            end else if (next_row < end_ff) begin
               cur_in   = next_row;
               state_in = S_SRD;
            end else if (lvl_ff == KMAX) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_OOM;
               state_in      = S_IDLE;
            end else begin
               // next order up sits just below this one in the node numbering
               lvl_in   = lvl_ff + KW'(1);
               cur_in   = lvl_base(lvl_ff + KW'(1));
               end_in   = lvl_base(lvl_ff);
               state_in = S_SRD;
            end
         end
         S_FRD: begin
            if (lvl_ff == KMAX) begin
               tlvl_in  = lvl_ff;
               toff_in  = off_ff;
               tval_in  = 1'b1;
               state_in = S_WRD;
            end else begin
               rd_addr  = bn[5 +: RW];
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (rd_data[bn[4:0]]) begin
               wr_en    = 1'b1;
               wr_addr  = bn[5 +: RW];
               wr_data  = rd_data & ~(ROW_W'(1) << bn[4:0]);
               off_in   = off_ff & ~(OW'(1) << lvl_ff);
               lvl_in   = lvl_ff + KW'(1);
               state_in = S_FRD;
            end else begin
               tlvl_in  = lvl_ff;
               toff_in  = off_ff;
               tval_in  = 1'b1;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            rd_addr  = tn[5 +: RW];
            state_in = S_WMOD;
         end
         S_WMOD: begin
            wr_en   = 1'b1;
            wr_addr = tn[5 +: RW];
            wr_data = row_mod;
            if (alloc_ff && tlvl_ff > k_ff) begin
               // split: free the upper half one order down
               tlvl_in  = tlvl_ff - KW'(1);
               toff_in  = off_ff ^ (OW'(1) << (tlvl_ff - KW'(1)));
               tval_in  = 1'b1;
               state_in = S_WRD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.granted_address = alloc_ff ? (base_ff + 32'(off_ff)) : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

/* hw/rtl/bdy_chk.sv */
module bdy_chk (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input bdy_pkg::rsp_type rsp_item
);
   import bdy_pkg::*;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted request neither worked on nor answered");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result beat without a request");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |-> rsp_item.granted_address == '0)
      else $error("nonzero address on failed request");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.status == ST_OK || rsp_item.status == ST_BAD_SIZE ||
                    rsp_item.status == ST_OOM || rsp_item.status == ST_OOB ||
                    rsp_item.status == ST_DISABLED)
      else $error("undefined status code");

endmodule

bind buddy_allocator bdy_chk u_bdy_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

/* tb/sv/buddy_allocator_checker.sv */
`timescale 1ns / 1ps
module buddy_allocator_checker #(
   parameter int MAX_ORDER = 16,
   parameter int MIN_ORDER = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  bdy_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  bdy_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data,
   output int               pending,
   output int               fail_count
);
   import bdy_pkg::*;

   localparam int MAP_DEPTH = (1 << (MAX_ORDER - MIN_ORDER + 1)) - 1;
   localparam longint REGION = longint'(1) << MAX_ORDER;

   bit          block_free[MAP_DEPTH];
   logic [31:0] base_reg;
   logic        enabled_reg;
   rsp_type     grant_q[$];

   function automatic int node_index(int k, longint off);
      return ((1 << (MAX_ORDER - k)) - 1) + int'(off >> k);
   endfunction

   function automatic int size_order(longint sz);
      int k;
      k = MIN_ORDER;
      while (k < MAX_ORDER && (longint'(1) << k) < sz) k++;
      return k;
   endfunction

   task automatic predict_grant(input req_type r, output rsp_type res);
      int     k, j, n;
      longint off, bud, sz, addr, base;
      bit     found;
      res = '0;
      res.status = ST_OK;
      sz = r.req_size;
      addr = r.req_address;
      base = base_reg;
      off = 0;
      if (r.func == FUNC_ALLOC) begin
         if (!enabled_reg) begin
            res.status = ST_DISABLED;
         end else if (sz == 0 || sz > REGION) begin
            res.status = ST_BAD_SIZE;
         end else begin
            k = size_order(sz);
            j = k;
            found = 0;
            // lowest free block of the smallest order that has one
            while (j <= MAX_ORDER && !found) begin
               n = (1 << (MAX_ORDER - j)) - 1;
               for (int i = 0; i < (1 << (MAX_ORDER - j)); i++) begin
                  if (block_free[n + i]) begin
                     off = longint'(i) << j;
                     found = 1;
                     break;
                  end
               end
               if (!found) j++;
            end
            if (!found) begin
               res.status = ST_OOM;
            end else begin
               block_free[node_index(j, off)] = 0;
               while (j > k) begin
                  j--;
                  block_free[node_index(j, off ^ (longint'(1) << j))] = 1;
               end
               res.granted_address = 32'(base + off);
            end
         end
      end else begin
         if (addr < base || addr >= base + REGION) begin
            res.status = ST_OOB;
         end else if (sz == 0 || sz > REGION) begin
            res.status = ST_BAD_SIZE;
         end else begin
            k = size_order(sz);
            off = (addr - base) & ~((longint'(1) << k) - 1);
            while (k < MAX_ORDER) begin
               bud = off ^ (longint'(1) << k);
               if (!block_free[node_index(k, bud)]) break;
               block_free[node_index(k, bud)] = 0;
               off &= ~(longint'(1) << k);
               k++;
            end
            block_free[node_index(k, off)] = 1;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want, got;
      if (reset) begin
         foreach (block_free[i]) block_free[i] = 0;
         block_free[0] = 1;
         base_reg = '0;
         enabled_reg = 0;
         grant_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_REGION_BASE) base_reg = csr_data;
            else enabled_reg = csr_data[0];
         end
         if (rsp_valid) begin
            got = rsp_item;
            if (grant_q.size() == 0) begin
               $error("unexpected result beat: granted_address %h status %0d",
                      got.granted_address, got.status);
               fail_count++;
            end else begin
               want = grant_q.pop_front();
               if (got.granted_address !== want.granted_address) begin
                  $error("granted_address: expected %h, got %h",
                         want.granted_address, got.granted_address);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_grant(req_item, want);
            grant_q.push_back(want);
         end
      end
      pending = grant_q.size();
   end

endmodule

/* tb/sv/buddy_allocator_test.sv */
`timescale 1ns / 1ps
module buddy_allocator_test;
   import bdy_pkg::*;

   localparam int MAX_ORDER = 16;
   localparam int REGION = 1 << MAX_ORDER;
   localparam longint CYCLE_LIMIT = 20_000_000;

   typedef struct {
      logic [31:0] addr;
      int          size;
   } live_block_type;

   logic           clock = 0;
   logic           reset = 1;
   logic           start = 0;
   logic           busy;
   req_type        req_item = '0;
   logic           rsp_valid;
   rsp_type        rsp_item;
   logic           csr_valid = 0;
   logic           csr_ready;
   logic           csr_index = CSR_REGION_BASE;
   logic [31:0]    csr_data = '0;
   int             pending;
   int             fail_count;
   longint         cycles = 0;
   logic [31:0]    region_base = '0;
   bit             no_gaps = 0;

   int             sent_sizes[$];   // -1 marks a free beat
   live_block_type live[$];

   buddy_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   buddy_allocator_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .pending(pending), .fail_count(fail_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // track granted blocks so later frees hit real allocations
   always @(posedge clock) begin
      live_block_type b;
      int sz;
      if (!reset && rsp_valid && sent_sizes.size() != 0) begin
         sz = sent_sizes.pop_front();
         if (sz >= 0 && rsp_item.status == ST_OK) begin
            b.addr = rsp_item.granted_address;
            b.size = sz;
            live.push_back(b);
         end
      end
   end

   task automatic send(input logic func, input int size, input logic [31:0] addr);
      int gap;
      req_item <= '{func: func, req_size: 17'(size), req_address: addr};
      start <= 1;
      do @(posedge clock); while (busy);
      sent_sizes.push_back(func == FUNC_ALLOC ? size : -1);
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_REGION_BASE && data != region_base) live.delete();
      if (idx == CSR_REGION_BASE) region_base = data;
   endtask

   task automatic alloc_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) send(FUNC_ALLOC, $urandom_range(1, 64), $urandom);
      else if (r < 95) send(FUNC_ALLOC, $urandom_range(65, 4096), $urandom);
      else send(FUNC_ALLOC, $urandom_range(4097, REGION), $urandom);
   endtask

   initial begin
      int r, idx;
      live_block_type b;
      logic [31:0] nb;
      repeat (2) @(posedge clock);
      reset <= 0;

      // disabled and error beats before the allocator is enabled
      send(FUNC_ALLOC, 8, '0);
      send(FUNC_FREE, 0, '0);
      send(FUNC_FREE, 8, 32'hFFFF_FFFF);
      send(FUNC_FREE, 131071, 32'h0000_0010);
      drain();
      write_csr(CSR_ENABLED, 32'h1);
      send(FUNC_ALLOC, 0, '0);
      send(FUNC_ALLOC, 131071, '0);
      send(FUNC_ALLOC, REGION + 1, '0);
      send(FUNC_ALLOC, REGION, '0);
      send(FUNC_ALLOC, 1, '0);               // out of memory
      send(FUNC_FREE, REGION, '0);
      send(FUNC_ALLOC, 1, '0);
      send(FUNC_ALLOC, 9, '0);
      send(FUNC_ALLOC, 16, '0);
      send(FUNC_FREE, 8, 32'h0000_0003);     // misaligned, aligns down
      send(FUNC_FREE, 8, 32'h0000_0000);     // double free
      send(FUNC_FREE, 16, 32'h0000_0010);
      send(FUNC_FREE, 32, 32'h0000_0020);
      send(FUNC_FREE, 8, 32'h0001_0000);     // just past the region
      drain();
      write_csr(CSR_REGION_BASE, 32'hFFFF_0000);
      send(FUNC_ALLOC, 32768, '0);
      send(FUNC_ALLOC, 32768, '0);
      send(FUNC_FREE, 32768, 32'hFFFF_8000);
      send(FUNC_FREE, 32768, 32'hFFFF_0000);
      send(FUNC_FREE, 8, 32'hFFFE_FFFF);
      drain();
      write_csr(CSR_ENABLED, 32'h0);
      send(FUNC_ALLOC, 8, '0);
      send(FUNC_FREE, 8, 32'hFFFF_0008);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph % 4)
            0: nb = 32'h0000_0000;
            1: nb = 32'hFFFF_0000;
            default: nb = {16'($urandom_range(0, 65535)), 16'h0};
         endcase
         write_csr(CSR_REGION_BASE, nb);
         write_csr(CSR_ENABLED, (ph == 5) ? 32'h0 : 32'h1);
         no_gaps = (ph % 3 == 1);
         for (int n = 0; n < 200; n++) begin
            r = $urandom_range(0, 99);
            if (live.size() > 150) r = 60;
            if (r < 50 || (r < 88 && live.size() == 0)) begin
               alloc_random();
            end else if (r < 88) begin
               idx = $urandom_range(0, live.size() - 1);
               b = live[idx];
               live.delete(idx);
               send(FUNC_FREE, b.size, b.addr);
            end else if (r < 94) begin
               send(FUNC_FREE, $urandom_range(0, 131071),
                    region_base + $urandom_range(0, REGION - 1));
            end else begin
               send(1'($urandom), $urandom_range(0, 131071), $urandom);
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
